>>> design/bru_pkg.sv
// Package for the row upscaler: sizes, status and register codes, and the
// structs passed between the control logic, the line buffer and the top level.
// No dependencies.
`default_nettype none

package bru_pkg;

   // Buffer and factor limits
   localparam int MAX_WIDTH = 4096;
   localparam int MAX_SCALE = 100;

   // Field widths
   localparam int PIXEL_W  = 24;
   localparam int FACTOR_W = 7;
   localparam int WIDTH_W  = 13;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int WCOL_W   = $clog2(MAX_WIDTH + 1);

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_FACTOR = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_WIDTH    = CSR_INDEX_W'(1);

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Element kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_PAD   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ELEMENT   = 2'd0,
      STATUS_WRITTEN   = 2'd1,
      STATUS_NOT_READY = 2'd2,
      STATUS_BUSY      = 2'd3
   } bru_status_type;

   typedef struct packed {
      logic               operation;
      logic [PIXEL_W-1:0] pixel_in;
   } bru_req_type;

   typedef struct packed {
      bru_status_type     status;
      logic               element_kind;
      logic [PIXEL_W-1:0] pixel_out;
      logic               row_end;
      logic               source_row_done;
   } bru_rsp_type;

   // Result fields decided at accept time; pixel data follows from the buffer
   typedef struct packed {
      bru_rsp_type rsp;
      logic        pixel_sel;
   } bru_meta_type;

   // Line buffer access for one transaction
   typedef struct packed {
      logic               wr_en;
      logic [COL_W-1:0]   wr_addr;
      logic [PIXEL_W-1:0] wr_data;
      logic               rd_en;
      logic [COL_W-1:0]   rd_addr;
   } bru_ram_cmd_type;

endpackage

`default_nettype wire

>>> design/bru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bru_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; hold data when not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/bru_ctrl.sv
// Row and repeat counters of the upscaler: decides each transaction's result
// and line buffer access. Depends on bru_pkg.
`default_nettype none

module bru_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire bru_pkg::bru_req_type           req,
   input  wire logic [bru_pkg::FACTOR_W-1:0]   scale_factor,
   input  wire logic [bru_pkg::WIDTH_W-1:0]    row_width,
   output bru_pkg::bru_meta_type               meta,
   output bru_pkg::bru_ram_cmd_type            ram_cmd
);

   import bru_pkg::*;

   logic [WCOL_W-1:0]   write_column_ff, write_column_in;
   logic                row_pending_ff, row_pending_in;
   logic [COL_W-1:0]    read_column_ff, read_column_in;
   logic [FACTOR_W-1:0] horizontal_repeat_ff, horizontal_repeat_in;
   logic [FACTOR_W-1:0] vertical_repeat_ff, vertical_repeat_in;
   logic [1:0]          pad_count_ff, pad_count_in;
   logic                in_padding_ff, in_padding_in;

   logic [FACTOR_W-1:0] factor;
   logic [WIDTH_W-1:0]  width;
   logic [1:0]          pads;
   logic [WCOL_W-1:0]   wcol_next;
   logic [WCOL_W-1:0]   rcol_next;
   logic [FACTOR_W:0]   h_next;
   logic [FACTOR_W:0]   v_next;
   logic [1:0]          pc_next;
   logic                rend;

   // Clamp the configuration to its legal range
   always_comb begin
      if (scale_factor == '0) begin
         factor = FACTOR_W'(1);
      end else if (scale_factor > FACTOR_W'(MAX_SCALE)) begin
         factor = FACTOR_W'(MAX_SCALE);
      end else begin
         factor = scale_factor;
      end
      if (row_width == '0) begin
         width = WIDTH_W'(1);
      end else if (row_width > WIDTH_W'(MAX_WIDTH)) begin
         width = WIDTH_W'(MAX_WIDTH);
      end else begin
         width = row_width;
      end
      pads = 2'(width[1:0] * factor[1:0]);
   end

   // Next state and result for the transaction at the input
   always_comb begin
      write_column_in      = write_column_ff;
      row_pending_in       = row_pending_ff;
      read_column_in       = read_column_ff;
      horizontal_repeat_in = horizontal_repeat_ff;
      vertical_repeat_in   = vertical_repeat_ff;
      pad_count_in         = pad_count_ff;
      in_padding_in        = in_padding_ff;

      meta    = '0;
      ram_cmd = '0;
      rend    = 1'b0;

      wcol_next = write_column_ff + WCOL_W'(1);
      rcol_next = WCOL_W'(read_column_ff) + WCOL_W'(1);
      h_next    = {1'b0, horizontal_repeat_ff} + (FACTOR_W+1)'(1);
      v_next    = {1'b0, vertical_repeat_ff} + (FACTOR_W+1)'(1);
      pc_next   = pad_count_ff + 2'd1;

      ram_cmd.wr_addr = write_column_ff[COL_W-1:0];
      ram_cmd.wr_data = req.pixel_in;
      ram_cmd.rd_addr = read_column_ff;

      if (req.operation == OP_WRITE) begin
         if (row_pending_ff) begin
            meta.rsp.status = STATUS_BUSY;
         end else begin
            meta.rsp.status = STATUS_WRITTEN;
            ram_cmd.wr_en   = (write_column_ff < WCOL_W'(MAX_WIDTH));
            write_column_in = wcol_next;
            // Row complete: start the replay
            if (wcol_next >= WCOL_W'(width)) begin
               write_column_in      = '0;
               row_pending_in       = 1'b1;
               read_column_in       = '0;
               horizontal_repeat_in = '0;
               vertical_repeat_in   = '0;
               pad_count_in         = '0;
               in_padding_in        = 1'b0;
            end
         end
      end else if (!row_pending_ff) begin
         meta.rsp.status = STATUS_NOT_READY;
      end else begin
         meta.rsp.status = STATUS_ELEMENT;
         if (in_padding_ff) begin
            // Emit one zero pad byte
            meta.rsp.element_kind = KIND_PAD;
            pad_count_in = pc_next;
            if (pc_next == 2'd0 || pc_next >= pads) begin
               pad_count_in  = '0;
               in_padding_in = 1'b0;
               rend          = 1'b1;
            end
         end else begin
            // Emit the current pixel, advance after factor repeats
            meta.rsp.element_kind = KIND_PIXEL;
            meta.pixel_sel        = 1'b1;
            ram_cmd.rd_en         = 1'b1;
            horizontal_repeat_in  = h_next[FACTOR_W-1:0];
            if (h_next >= {1'b0, factor}) begin
               horizontal_repeat_in = '0;
               read_column_in       = rcol_next[COL_W-1:0];
               if (rcol_next >= WCOL_W'(width)) begin
                  read_column_in = '0;
                  if (pads != 2'd0) begin
                     in_padding_in = 1'b1;
                     pad_count_in  = '0;
                  end else begin
                     rend = 1'b1;
                  end
               end
            end
         end
         // Count output rows; drop the source row after the last one
         if (rend) begin
            vertical_repeat_in = v_next[FACTOR_W-1:0];
            if (v_next >= {1'b0, factor}) begin
               vertical_repeat_in       = '0;
               row_pending_in           = 1'b0;
               meta.rsp.source_row_done = 1'b1;
            end
         end
      end
      meta.rsp.row_end = rend;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_column_ff      <= '0;
         row_pending_ff       <= 1'b0;
         read_column_ff       <= '0;
         horizontal_repeat_ff <= '0;
         vertical_repeat_ff   <= '0;
         pad_count_ff         <= '0;
         in_padding_ff        <= 1'b0;
      end else if (accept) begin
         write_column_ff      <= write_column_in;
         row_pending_ff       <= row_pending_in;
         read_column_ff       <= read_column_in;
         horizontal_repeat_ff <= horizontal_repeat_in;
         vertical_repeat_ff   <= vertical_repeat_in;
         pad_count_ff         <= pad_count_in;
         in_padding_ff        <= in_padding_in;
      end
   end

`ifndef SYNTHESIS
   // A finished source row always ends an output row
   a_done_ends_row: assert property (@(posedge clock) disable iff (reset)
      accept && meta.rsp.source_row_done |-> meta.rsp.row_end)
      else $error("source row done without row end");

   // Finishing the last output row frees the buffer for writes
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      accept && meta.rsp.source_row_done |=> !row_pending_ff)
      else $error("row still pending after source row done");

   // Padding is only entered while a row is being replayed
   a_pad_pending: assert property (@(posedge clock) disable iff (reset)
      in_padding_ff |-> row_pending_ff)
      else $error("padding without a pending row");

   // Write pointer never runs past the buffer
   a_wcol_range: assert property (@(posedge clock) disable iff (reset)
      write_column_ff < WCOL_W'(MAX_WIDTH))
      else $error("write column out of range");
`endif

endmodule

`default_nettype wire

>>> design/bmp_row_integer_upscaler.sv
// Top level of the nearest-neighbor row upscaler: configuration registers,
// output register and line buffer. Depends on bru_pkg, bru_ctrl, bru_ram.
//
// Usage:
//   req channel (req_valid / req_stall / req_payload): one transaction is a
//   pixel write or a request for the next output element. Write a source row
//   of row_width pixels, then issue reads; each read returns one pixel or one
//   zero pad byte of the enlarged image, row_end on the last element of each
//   output row and source_row_done on the last element of the last repeat.
//   rsp channel (rsp_valid / rsp_stall / rsp_payload): exactly one result per
//   transaction, in order, in the cycle after it is accepted.
//   csr channel (csr_valid / csr_ready, always ready): index 0 scale_factor,
//   index 1 row_width; other indexes are ignored. Write only while idle.
// Throughput is one transaction per cycle while rsp_stall is low: each touches
// one line buffer entry (single write port, single registered read port) and
// the counters. Reset clears the counters and the output valid flag and sets
// both configuration registers to 1; the line buffer keeps its contents. While
// the receiver stalls, the result holds in the output register and req_stall
// is raised, so no further transaction is taken until the result is delivered.
`default_nettype none

module bmp_row_integer_upscaler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire bru_pkg::bru_req_type             req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output bru_pkg::bru_rsp_type                  rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bru_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bru_pkg::CSR_DATA_W-1:0]   csr_data
);

   import bru_pkg::*;

   logic [FACTOR_W-1:0] scale_factor_ff;
   logic [WIDTH_W-1:0]  row_width_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   bru_meta_type        meta_ff;
   bru_meta_type        meta;
   bru_ram_cmd_type     ram_cmd;
   logic [PIXEL_W-1:0]  rd_data;
   logic                accept;

   // Handshake: take a transaction whenever the output register frees up
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= FACTOR_W'(1);
         row_width_ff    <= WIDTH_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SCALE_FACTOR: scale_factor_ff <= csr_data[FACTOR_W-1:0];
            REG_ROW_WIDTH:    row_width_ff    <= csr_data[WIDTH_W-1:0];
            default:          ;
         endcase
      end
   end

   bru_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_payload),
      .scale_factor (scale_factor_ff),
      .row_width    (row_width_ff),
      .meta         (meta),
      .ram_cmd      (ram_cmd)
   );

   bru_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (accept && ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (accept && ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load on accept, clear once delivered
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta;
      end
   end

   // Merge buffer data into pixel elements
   always_comb begin
      rsp_payload           = meta_ff.rsp;
      rsp_payload.pixel_out = meta_ff.pixel_sel ? rd_data : '0;
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // Every accepted transaction yields a result in the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // Buffer data only goes out on valid pixel elements
   a_pixel_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && meta_ff.pixel_sel |->
         rsp_payload.status == STATUS_ELEMENT && rsp_payload.element_kind == KIND_PIXEL)
      else $error("pixel data on a non-pixel result");

   // Pad bytes carry zero data
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.element_kind == KIND_PAD |-> rsp_payload.pixel_out == '0)
      else $error("pad byte with nonzero data");
`endif

endmodule

`default_nettype wire
